>>> design/fcma_pkg.sv
// fcma_pkg: shared constants and helpers for the four-channel moving average
// no dependencies; imported by fcma_channel and four_channel_moving_average_top
`timescale 1ns / 1ps

package fcma_pkg;

  // default configuration of the filter
  localparam int LONG_WINDOW_DEF  = 32;
  localparam int SHORT_WINDOW_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 12;

  // reset value of the current offset register
  localparam int OFFSET_RESET = 220;

  // register map, word index
  localparam int REG_CURRENT_OFFSET = 0;

  // right shift that turns a window sum into an average: floor(log2(depth))
  function automatic int avg_shift(input int depth);
    return $clog2(depth + 1) - 1;
  endfunction

endpackage

>>> design/fcma_cell.sv
// fcma_cell: one window entry of a channel's sample line
// depends on nothing; instantiated in a row by fcma_channel
`timescale 1ns / 1ps

module fcma_cell #(
  parameter int WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift) begin
      entry <= din;
    end
  end

  assign dout = entry;

endmodule

>>> design/fcma_channel.sv
// fcma_channel: one boxcar channel, a row of fcma_cell plus the running sum
// depends on fcma_pkg and fcma_cell
`timescale 1ns / 1ps

module fcma_channel #(
  parameter int WIDTH     = 12,
  parameter int DEPTH     = 32,
  parameter bit IS_SIGNED = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] avg
);

  import fcma_pkg::*;

  localparam int SH = avg_shift(DEPTH);
  localparam int EW = $clog2(DEPTH);
  localparam int TW = WIDTH + EW;

  logic [WIDTH-1:0] tap [DEPTH+1];
  logic [TW-1:0]    total;
  logic [TW-1:0]    total_next;
  logic [TW-1:0]    new_ext;
  logic [TW-1:0]    old_ext;
  logic [SH+TW-1:0] shifted;

  assign tap[0] = din;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    fcma_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .din  (tap[k]),
      .dout (tap[k+1])
    );
  end

  // last cell holds the oldest entry, the one that leaves the window
  assign new_ext    = {{EW{IS_SIGNED & din[WIDTH-1]}}, din};
  assign old_ext    = {{EW{IS_SIGNED & tap[DEPTH][WIDTH-1]}}, tap[DEPTH]};
  assign total_next = total - old_ext + new_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (shift) begin
      total <= total_next;
    end
  end

  // arithmetic shift for the signed channel, rounds toward minus infinity
  assign shifted = {{SH{IS_SIGNED & total[TW-1]}}, total} >> SH;
  assign avg     = shifted[WIDTH-1:0];

endmodule

>>> design/four_channel_moving_average_top.sv
// four_channel_moving_average_top: four-channel boxcar filter for adc conversion sets
// depends on fcma_pkg, fcma_channel and fcma_cell
`timescale 1ns / 1ps
//
// usage
//   sample channel: one beat per conversion set (vout, iout, vbat, temp samples),
//   taken when sample_valid and sample_ready are both high
//   avg channel: one beat of four averages per accepted set, taken when avg_valid
//   and avg_ready are both high
//   apb port: one register, current_offset at byte address 0, subtracted from
//   every current sample; write it only while no beat is in flight
// output: the averages of a set appear in the cycle after its beat is accepted
// throughput: one set per cycle while avg_ready is high; each channel's running sum adds the new sample
//   and drops the oldest in the same cycle, the sample line shifts in step
// stall: while avg_valid is high and avg_ready low, the result holds and
//   sample_ready is low; ready returns in the cycle the result is taken
// reset: sample lines and running sums clear to zero, offset goes to 220,
//   avg_valid drops, sample_ready is low while rst is high
//
module four_channel_moving_average_top #(
  parameter int LONG_WINDOW  = fcma_pkg::LONG_WINDOW_DEF,
  parameter int SHORT_WINDOW = fcma_pkg::SHORT_WINDOW_DEF,
  parameter int SAMPLE_BITS  = fcma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // conversion set
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [SAMPLE_BITS-1:0]        vout_sample,
  input  logic [SAMPLE_BITS-1:0]        iout_sample,
  input  logic [SAMPLE_BITS-1:0]        vbat_sample,
  input  logic [SAMPLE_BITS-1:0]        temp_sample,
  // averages
  output logic                          avg_valid,
  input  logic                          avg_ready,
  output logic [SAMPLE_BITS-1:0]        vout_avg,
  output logic signed [SAMPLE_BITS:0]   iout_avg,
  output logic [SAMPLE_BITS-1:0]        vbat_avg,
  output logic [SAMPLE_BITS-1:0]        temp_avg,
  // apb register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import fcma_pkg::*;

  logic [SAMPLE_BITS-1:0] current_offset;
  logic                   reg_write;
  logic                   reg_hit;
  logic                   accept;
  logic [SAMPLE_BITS:0]   iout_corr;
  logic [SAMPLE_BITS-1:0] temp_inv;
  logic [SAMPLE_BITS:0]   iout_avg_raw;

  // ---------------------------------------------------------------- register port
  assign pready    = 1'b1;
  // word index sits in paddr[2]; anything but index zero is ignored
  assign reg_hit   = (paddr[2] == 1'(REG_CURRENT_OFFSET));
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_offset <= SAMPLE_BITS'(OFFSET_RESET);
    end else if (reg_write && reg_hit) begin
      current_offset <= pwdata[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[SAMPLE_BITS-1:0] = current_offset;
    end
  end

  // ---------------------------------------------------------------- handshake
  // the running sums double as the output register, so a new beat may enter
  // only when the slot is empty or being drained this cycle
  assign sample_ready = !rst && (!avg_valid || avg_ready);
  assign accept       = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (accept) begin
      avg_valid <= 1'b1;
    end else if (avg_ready) begin
      avg_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- input shaping
  // offset-corrected current, one bit wider, two's complement
  assign iout_corr = {1'b0, iout_sample} - {1'b0, current_offset};
  // full scale minus sample is the bitwise complement
  assign temp_inv  = ~temp_sample;

  // ---------------------------------------------------------------- channels
  fcma_channel #(
    .WIDTH    (SAMPLE_BITS),
    .DEPTH    (LONG_WINDOW),
    .IS_SIGNED(1'b0)
  ) u_vout (
    .clk  (clk),
    .rst  (rst),
    .shift(accept),
    .din  (vout_sample),
    .avg  (vout_avg)
  );

  fcma_channel #(
    .WIDTH    (SAMPLE_BITS + 1),
    .DEPTH    (LONG_WINDOW),
    .IS_SIGNED(1'b1)
  ) u_iout (
    .clk  (clk),
    .rst  (rst),
    .shift(accept),
    .din  (iout_corr),
    .avg  (iout_avg_raw)
  );

  assign iout_avg = $signed(iout_avg_raw);

  fcma_channel #(
    .WIDTH    (SAMPLE_BITS),
    .DEPTH    (LONG_WINDOW),
    .IS_SIGNED(1'b0)
  ) u_vbat (
    .clk  (clk),
    .rst  (rst),
    .shift(accept),
    .din  (vbat_sample),
    .avg  (vbat_avg)
  );

  // temperature runs on the short window
  fcma_channel #(
    .WIDTH    (SAMPLE_BITS),
    .DEPTH    (SHORT_WINDOW),
    .IS_SIGNED(1'b0)
  ) u_temp (
    .clk  (clk),
    .rst  (rst),
    .shift(accept),
    .din  (temp_inv),
    .avg  (temp_avg)
  );

endmodule

>>> design/fcma_checker.sv
// fcma_checker: port-level checks for four_channel_moving_average_top
// depends on nothing but the top level's ports; bound to the top below
`timescale 1ns / 1ps

module fcma_checker (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_ready,
  input logic avg_valid,
  input logic avg_ready
);

  // a result that is not taken stays offered
  a_avg_hold: assert property (@(posedge clk) disable iff (rst)
    avg_valid && !avg_ready |=> avg_valid)
    else $error("avg beat dropped while stalled");

  // a set is taken only when the result slot is free or drains this cycle
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    sample_ready == (!avg_valid || avg_ready))
    else $error("sample_ready does not follow the result slot");

  // every accepted set yields a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> avg_valid)
    else $error("accepted set produced no result");

  // reset empties the result slot
  a_reset: assert property (@(posedge clk)
    rst |=> !avg_valid)
    else $error("result offered right after reset");

endmodule

bind four_channel_moving_average_top fcma_checker u_fcma_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_ready(sample_ready),
  .avg_valid   (avg_valid),
  .avg_ready   (avg_ready)
);
